// File: rtl/atcd_pkg.sv
// shared types, class codes and the masked-pattern tables of the instruction class decoder
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package atcd_pkg;

    // decode modes
    localparam logic [1:0] MODE_ARM_KEY    = 2'd0;
    localparam logic [1:0] MODE_ARM_UNCOND = 2'd1;
    localparam logic [1:0] MODE_THUMB_KEY  = 2'd2;
    localparam logic [1:0] MODE_THUMB_MISC = 2'd3;

    // longest pattern list and the index width that covers it
    localparam int MaxPat = 27;
    localparam int IdxW   = $clog2(MaxPat);

    // execute classes
    localparam logic [5:0] EX_UNDEF    = 6'd0;
    localparam logic [5:0] EX_MUL      = 6'd1;
    localparam logic [5:0] EX_MRS      = 6'd2;
    localparam logic [5:0] EX_MSR      = 6'd3;
    localparam logic [5:0] EX_BX       = 6'd4;
    localparam logic [5:0] EX_CLZ      = 6'd5;
    localparam logic [5:0] EX_QMATH    = 6'd6;
    localparam logic [5:0] EX_BKPT     = 6'd7;
    localparam logic [5:0] EX_UNIMP    = 6'd8;
    localparam logic [5:0] EX_LSMISC   = 6'd9;
    localparam logic [5:0] EX_LDC      = 6'd10;
    localparam logic [5:0] EX_DP       = 6'd11;
    localparam logic [5:0] EX_LS       = 6'd12;
    localparam logic [5:0] EX_MCR      = 6'd13;
    localparam logic [5:0] EX_MRC      = 6'd14;
    localparam logic [5:0] EX_B        = 6'd15;
    localparam logic [5:0] EX_SWI      = 6'd16;
    localparam logic [5:0] EX_BLXI     = 6'd17;
    localparam logic [5:0] EX_MCR2     = 6'd18;
    localparam logic [5:0] EX_MRC2     = 6'd19;
    localparam logic [5:0] EX_T_ADDSUB = 6'd20;
    localparam logic [5:0] EX_T_SHIFT  = 6'd21;
    localparam logic [5:0] EX_T_MOV    = 6'd22;
    localparam logic [5:0] EX_T_DPIMM  = 6'd23;
    localparam logic [5:0] EX_T_DPREG  = 6'd24;
    localparam logic [5:0] EX_T_HIREG  = 6'd25;
    localparam logic [5:0] EX_T_LDRPC  = 6'd26;
    localparam logic [5:0] EX_T_LSREG  = 6'd27;
    localparam logic [5:0] EX_T_LSW    = 6'd28;
    localparam logic [5:0] EX_T_LSB    = 6'd29;
    localparam logic [5:0] EX_T_LSH    = 6'd30;
    localparam logic [5:0] EX_T_LSSP   = 6'd31;
    localparam logic [5:0] EX_T_ADDR   = 6'd32;
    localparam logic [5:0] EX_T_MISC   = 6'd33;
    localparam logic [5:0] EX_T_BCOND  = 6'd34;
    localparam logic [5:0] EX_T_B      = 6'd35;
    localparam logic [5:0] EX_T_ADJSP  = 6'd36;
    localparam logic [5:0] EX_T_PUSH   = 6'd37;
    localparam logic [5:0] EX_T_POP    = 6'd38;

    // interlock groups
    localparam logic [5:0] IL_MUL       = 6'd0;
    localparam logic [5:0] IL_MRS       = 6'd1;
    localparam logic [5:0] IL_MSR       = 6'd2;
    localparam logic [5:0] IL_BX        = 6'd3;
    localparam logic [5:0] IL_CLZ       = 6'd4;
    localparam logic [5:0] IL_QMATH     = 6'd5;
    localparam logic [5:0] IL_ARM_UNIMP = 6'd6;
    localparam logic [5:0] IL_LSMISC    = 6'd7;
    localparam logic [5:0] IL_LDC       = 6'd8;
    localparam logic [5:0] IL_DP        = 6'd9;
    localparam logic [5:0] IL_LS        = 6'd10;
    localparam logic [5:0] IL_MCR       = 6'd11;
    localparam logic [5:0] IL_MRC       = 6'd12;
    localparam logic [5:0] IL_B         = 6'd13;
    localparam logic [5:0] IL_T_ADDSUB  = 6'd14;
    localparam logic [5:0] IL_T_SHIFT   = 6'd15;
    localparam logic [5:0] IL_T_MOV     = 6'd16;
    localparam logic [5:0] IL_T_DPIMM   = 6'd17;
    localparam logic [5:0] IL_T_DPREG   = 6'd18;
    localparam logic [5:0] IL_T_HIREG   = 6'd19;
    localparam logic [5:0] IL_T_LDRPC   = 6'd20;
    localparam logic [5:0] IL_T_LSREG   = 6'd21;
    localparam logic [5:0] IL_T_LSW     = 6'd22;
    localparam logic [5:0] IL_T_LSB     = 6'd23;
    localparam logic [5:0] IL_T_LSH     = 6'd24;
    localparam logic [5:0] IL_T_LSSP    = 6'd25;
    localparam logic [5:0] IL_T_ADDR    = 6'd26;
    localparam logic [5:0] IL_T_UNIMP   = 6'd27;
    localparam logic [5:0] IL_T_BCOND   = 6'd28;
    localparam logic [5:0] IL_T_B       = 6'd29;
    localparam logic [5:0] IL_T_ADJSP   = 6'd30;
    localparam logic [5:0] IL_T_PUSH    = 6'd31;
    localparam logic [5:0] IL_T_POP     = 6'd32;
    localparam logic [5:0] IL_NONE      = 6'd39;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] instr_word;
    } req_t;

    typedef struct packed {
        logic [5:0] exec_class;
        logic [5:0] interlock_class;
    } rsp_t;

    typedef struct packed {
        logic [31:0] cmp;
        logic [31:0] mask;
        logic [5:0]  exec_class;
        logic [5:0]  interlock_class;
    } pat_t;

    function automatic pat_t mk(input logic [31:0] cmp, input logic [31:0] mask,
                                input logic [5:0] ex, input logic [5:0] il);
        pat_t p;
        p.cmp             = cmp;
        p.mask            = mask;
        p.exec_class      = ex;
        p.interlock_class = il;
        return p;
    endfunction

    // entry idx of the list for mode; slots past the end never match
    function automatic pat_t pat_at(input logic [1:0] mode, input logic [IdxW-1:0] idx);
        pat_t p;
        p = mk(32'h1, 32'h0, EX_UNDEF, IL_NONE);
        case (mode)
            MODE_ARM_KEY:
            begin
                case (idx)
                    5'd0:    p = mk(32'h049, 32'hFCF, EX_UNDEF, IL_NONE);
                    5'd1:    p = mk(32'h009, 32'hF0F, EX_MUL, IL_MUL);
                    5'd2:    p = mk(32'h100, 32'hFBF, EX_MRS, IL_MRS);
                    5'd3:    p = mk(32'h120, 32'hFBF, EX_MSR, IL_MSR);
                    5'd4:    p = mk(32'h121, 32'hFFD, EX_BX, IL_BX);
                    5'd5:    p = mk(32'h161, 32'hFFF, EX_CLZ, IL_CLZ);
                    5'd6:    p = mk(32'h105, 32'hF9F, EX_QMATH, IL_QMATH);
                    5'd7:    p = mk(32'h127, 32'hFFF, EX_BKPT, IL_NONE);
                    5'd8:    p = mk(32'h108, 32'hF99, EX_UNIMP, IL_ARM_UNIMP);
                    5'd9:    p = mk(32'h109, 32'hFBF, EX_UNIMP, IL_ARM_UNIMP);
                    5'd10:   p = mk(32'h009, 32'hE09, EX_LSMISC, IL_LSMISC);
                    5'd11:   p = mk(32'h7FF, 32'hFFF, EX_UNDEF, IL_NONE);
                    5'd12:   p = mk(32'hC10, 32'hF10, EX_LDC, IL_LDC);
                    5'd13:   p = mk(32'hC00, 32'hF10, EX_UNIMP, IL_ARM_UNIMP);
                    5'd14:   p = mk(32'hC40, 32'hFF0, EX_UNIMP, IL_ARM_UNIMP);
                    5'd15:   p = mk(32'hC50, 32'hFF0, EX_UNIMP, IL_ARM_UNIMP);
                    5'd16:   p = mk(32'hC00, 32'hFA0, EX_UNIMP, IL_ARM_UNIMP);
                    5'd17:   p = mk(32'h000, 32'hC00, EX_DP, IL_DP);
                    5'd18:   p = mk(32'h400, 32'hC00, EX_LS, IL_LS);
                    5'd19:   p = mk(32'hE00, 32'hF01, EX_UNIMP, IL_ARM_UNIMP);
                    5'd20:   p = mk(32'hE01, 32'hF11, EX_MCR, IL_MCR);
                    5'd21:   p = mk(32'hE11, 32'hF11, EX_MRC, IL_MRC);
                    5'd22:   p = mk(32'h800, 32'hE00, EX_UNIMP, IL_ARM_UNIMP);
                    5'd23:   p = mk(32'hA00, 32'hE00, EX_B, IL_B);
                    5'd24:   p = mk(32'hF00, 32'hF00, EX_SWI, IL_NONE);
                    5'd25:   p = mk(32'hE00, 32'hF00, EX_UNIMP, IL_ARM_UNIMP);
                    5'd26:   p = mk(32'h000, 32'h000, EX_UNDEF, IL_NONE);
                    default: p = mk(32'h1, 32'h0, EX_UNDEF, IL_NONE);
                endcase
            end
            MODE_ARM_UNCOND:
            begin
                case (idx)
                    5'd0:    p = mk(32'hFA000000, 32'hFE000000, EX_BLXI, IL_NONE);
                    5'd1:    p = mk(32'hF550F000, 32'hFD70F000, EX_UNIMP, IL_ARM_UNIMP);
                    5'd2:    p = mk(32'hFE000010, 32'hFF100010, EX_MCR2, IL_MCR);
                    5'd3:    p = mk(32'hFE100010, 32'hFF100010, EX_MRC2, IL_MRC);
                    5'd4:    p = mk(32'hFE000000, 32'hFF000010, EX_UNIMP, IL_ARM_UNIMP);
                    5'd5:    p = mk(32'hFC100000, 32'hFE100000, EX_UNIMP, IL_LDC);
                    5'd6:    p = mk(32'hFC000000, 32'hFE100000, EX_UNIMP, IL_ARM_UNIMP);
                    5'd7:    p = mk(32'hFC400000, 32'hFFF00000, EX_UNIMP, IL_ARM_UNIMP);
                    5'd8:    p = mk(32'hFC500000, 32'hFFF00000, EX_UNIMP, IL_ARM_UNIMP);
                    5'd9:    p = mk(32'hF1200070, 32'hFFF000F0, EX_BKPT, IL_NONE);
                    5'd10:   p = mk(32'h00000000, 32'h00000000, EX_UNDEF, IL_NONE);
                    default: p = mk(32'h1, 32'h0, EX_UNDEF, IL_NONE);
                endcase
            end
            MODE_THUMB_KEY:
            begin
                case (idx)
                    5'd0:    p = mk(32'h06, 32'h3E, EX_T_ADDSUB, IL_T_ADDSUB);
                    5'd1:    p = mk(32'h00, 32'h38, EX_T_SHIFT, IL_T_SHIFT);
                    5'd2:    p = mk(32'h08, 32'h3E, EX_T_MOV, IL_T_MOV);
                    5'd3:    p = mk(32'h08, 32'h38, EX_T_DPIMM, IL_T_DPIMM);
                    5'd4:    p = mk(32'h10, 32'h3F, EX_T_DPREG, IL_T_DPREG);
                    5'd5:    p = mk(32'h11, 32'h3F, EX_T_HIREG, IL_T_HIREG);
                    5'd6:    p = mk(32'h12, 32'h3E, EX_T_LDRPC, IL_T_LDRPC);
                    5'd7:    p = mk(32'h14, 32'h3C, EX_T_LSREG, IL_T_LSREG);
                    5'd8:    p = mk(32'h18, 32'h3C, EX_T_LSW, IL_T_LSW);
                    5'd9:    p = mk(32'h1C, 32'h3C, EX_T_LSB, IL_T_LSB);
                    5'd10:   p = mk(32'h20, 32'h3C, EX_T_LSH, IL_T_LSH);
                    5'd11:   p = mk(32'h24, 32'h3C, EX_T_LSSP, IL_T_LSSP);
                    5'd12:   p = mk(32'h28, 32'h3C, EX_T_ADDR, IL_T_ADDR);
                    5'd13:   p = mk(32'h2C, 32'h3C, EX_T_MISC, IL_T_UNIMP);
                    5'd14:   p = mk(32'h30, 32'h3C, EX_UNIMP, IL_T_UNIMP);
                    5'd15:   p = mk(32'h34, 32'h3C, EX_T_BCOND, IL_T_BCOND);
                    5'd16:   p = mk(32'h38, 32'h38, EX_T_B, IL_T_B);
                    5'd17:   p = mk(32'h00, 32'h00, EX_UNDEF, IL_T_UNIMP);
                    default: p = mk(32'h1, 32'h0, EX_UNDEF, IL_NONE);
                endcase
            end
            MODE_THUMB_MISC:
            begin
                case (idx)
                    5'd0:    p = mk(32'h000, 32'h1E0, EX_T_ADJSP, IL_T_ADJSP);
                    5'd1:    p = mk(32'h080, 32'h1C0, EX_T_PUSH, IL_T_PUSH);
                    5'd2:    p = mk(32'h180, 32'h1C0, EX_T_POP, IL_T_POP);
                    5'd3:    p = mk(32'h1C0, 32'h1C0, EX_BKPT, IL_NONE);
                    5'd4:    p = mk(32'h000, 32'h000, EX_UNDEF, IL_NONE);
                    default: p = mk(32'h1, 32'h0, EX_UNDEF, IL_NONE);
                endcase
            end
            default: p = mk(32'h1, 32'h0, EX_UNDEF, IL_NONE);
        endcase
        return p;
    endfunction

endpackage

// File: rtl/atcd_match.sv
// first stage logic: forms the table key and compares it against every pattern of the mode
// depends on atcd_pkg
`timescale 1ns / 1ps

module atcd_match (
    input  atcd_pkg::req_t              req,
    output logic [atcd_pkg::MaxPat-1:0] hit
);
    import atcd_pkg::*;

    logic [31:0] key;
    pat_t        p;

    always_comb
    begin
        case (req.mode)
            MODE_ARM_KEY:    key = {20'd0, req.instr_word[11:0]};
            MODE_ARM_UNCOND: key = req.instr_word;
            MODE_THUMB_KEY:  key = {26'd0, req.instr_word[5:0]};
            MODE_THUMB_MISC: key = {23'd0, req.instr_word[11:3]};
            default:         key = req.instr_word;
        endcase
    end

    // every slot compared in parallel, unused slots never hit
    always_comb
    begin
        p = pat_at(req.mode, '0);
        for (int i = 0; i < MaxPat; i++)
        begin
            p      = pat_at(req.mode, IdxW'(i));
            hit[i] = ((key & p.mask) == p.cmp);
        end
    end

endmodule

// File: rtl/atcd_prio.sv
// second stage logic: priority encoder, lowest matching pattern index wins
// depends on atcd_pkg
`timescale 1ns / 1ps

module atcd_prio (
    input  logic [atcd_pkg::MaxPat-1:0] hit,
    output logic [atcd_pkg::IdxW-1:0]   idx
);
    import atcd_pkg::*;

    always_comb
    begin
        idx = '0;
        for (int i = MaxPat - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                idx = IdxW'(i);
            end
        end
    end

endmodule

// File: rtl/atcd_lookup.sv
// third stage logic: maps the winning pattern index to its execute and interlock classes
// depends on atcd_pkg
`timescale 1ns / 1ps

module atcd_lookup (
    input  logic [1:0]                mode,
    input  logic [atcd_pkg::IdxW-1:0] idx,
    output atcd_pkg::rsp_t            rsp
);
    import atcd_pkg::*;

    pat_t p;

    always_comb
    begin
        p                   = pat_at(mode, idx);
        rsp.exec_class      = p.exec_class;
        rsp.interlock_class = p.interlock_class;
    end

endmodule

// File: rtl/arm_thumb_instruction_class_decoder.sv
// ARM/Thumb instruction class decoder, top level: three-stage pipeline with valid/stall channels
// depends on atcd_pkg, atcd_match, atcd_prio, atcd_lookup
//
// usage:
//   req channel (req_valid, req_stall, req) carries one instruction or table key per beat,
//   req.mode picks the pattern list (arm key, arm unconditional word, thumb key, thumb misc)
//   rsp channel (rsp_valid, rsp_stall, rsp) returns exactly one beat per request, in order,
//   holding the execute class and the interlock group
// path: an accepted req beat passes the s1 (match), s2 (priority) and output (lookup) registers
// throughput: one beat per cycle unless rsp_stall holds the output; each stage holds one beat and
//   moves on whenever the stage after it is empty or moving, so bubbles are squeezed out
// reset: all stage valid bits clear, nothing is in flight, req_stall low
// receiver stall: the output register holds its beat unchanged; the stages behind it keep
//   filling, and req_stall rises only once all three stages hold a beat
`timescale 1ns / 1ps

module arm_thumb_instruction_class_decoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  atcd_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output atcd_pkg::rsp_t rsp
);
    import atcd_pkg::*;

    logic              s1_valid_reg;
    logic [1:0]        s1_mode_reg;
    logic [MaxPat-1:0] s1_hit_reg;
    logic [MaxPat-1:0] s1_hit_next;

    logic              s2_valid_reg;
    logic [1:0]        s2_mode_reg;
    logic [IdxW-1:0]   s2_idx_reg;
    logic [IdxW-1:0]   s2_idx_next;

    logic              out_valid_reg;
    rsp_t              out_reg;
    rsp_t              out_next;

    logic              s1_adv;
    logic              s2_adv;
    logic              out_adv;

    // a stage loads when it is empty or its beat moves on
    assign out_adv   = !out_valid_reg || !rsp_stall;
    assign s2_adv    = !s2_valid_reg || out_adv;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign req_stall = !s1_adv;

    atcd_match u_match (
        .req (req),
        .hit (s1_hit_next)
    );

    atcd_prio u_prio (
        .hit (s1_hit_reg),
        .idx (s2_idx_next)
    );

    atcd_lookup u_lookup (
        .mode (s2_mode_reg),
        .idx  (s2_idx_reg),
        .rsp  (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && req_valid)
        begin
            s1_mode_reg <= req.mode;
            s1_hit_reg  <= s1_hit_next;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_idx_reg  <= s2_idx_next;
        end
        if (out_adv && s2_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef ASSERT_OFF
    // every list ends in a catch-all, so a live beat always has a hit
    a_hit_present: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_hit_reg != '0))
        else $error("stage 1 beat without any pattern hit");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_idx_reg <= IdxW'(MaxPat - 1)))
        else $error("stage 2 index past the longest list");

    a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_adv) |=> s2_valid_reg)
        else $error("stage 1 beat dropped on its way to stage 2");

    a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_adv) |=> out_valid_reg)
        else $error("stage 2 beat dropped on its way to the output");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && rsp_stall))
        else $error("input stalled while the pipeline has room");
`endif

endmodule
